### rtl/assert_macros.svh
// Assertion macros shared by the lamp classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_IMPLY(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle implication violated");

`endif

### rtl/lbsc_pkg.sv
// Types and constants for the lamp blink/steady classifier.
package lbsc_pkg;

    localparam int TIME_W      = 32;
    localparam int BURST_W     = 10;
    localparam int THR_W       = 4;
    localparam int MS_W        = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEADY           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_TIMEOUT    = 3'd4;

    // register reset values
    localparam logic [THR_W-1:0] RST_ACTIVE_THRESHOLD = 4'd5;
    localparam logic [MS_W-1:0]  RST_POLL_INTERVAL    = 16'd20;
    localparam logic [MS_W-1:0]  RST_MAX_GAP          = 16'd100;
    localparam logic [MS_W-1:0]  RST_STEADY           = 16'd2000;
    localparam logic [MS_W-1:0]  RST_BLINK_TIMEOUT    = 16'd2500;

    typedef enum logic [1:0] {
        RUN_OFF      = 2'd0,
        RUN_BLINKING = 2'd1,
        RUN_STEADY   = 2'd2
    } run_state_t;

    // run lamp timing settings
    typedef struct packed {
        logic [MS_W-1:0] poll_interval_ms;
        logic [MS_W-1:0] max_gap_ms;
        logic [MS_W-1:0] steady_hold_ms;
        logic [MS_W-1:0] blink_timeout_ms;
    } run_cfg_t;

    // run lamp verdict for one item
    typedef struct packed {
        run_state_t state;
        logic       sampled;
    } run_res_t;

endpackage

### rtl/lbsc_burst_count.sv
// Active-sample count of one lamp burst against the lit threshold.
module lbsc_burst_count #(
    parameter int SAMPLE_COUNT = 10
) (
    input  logic [lbsc_pkg::BURST_W-1:0] samples,
    input  logic [lbsc_pkg::THR_W-1:0]   threshold,
    output logic                          lit
);
    import lbsc_pkg::*;

    // bits beyond the port width are never counted
    localparam int USED_W = (SAMPLE_COUNT < BURST_W) ? SAMPLE_COUNT : BURST_W;
    localparam int CNT_W  = $clog2(USED_W + 1);

    logic [CNT_W-1:0] count;

    always_comb
    begin
        count = '0;
        for (int i = 0; i < USED_W; i++)
        begin
            count = count + CNT_W'(samples[i]);
        end
    end

    assign lit = THR_W'(count) >= threshold;

endmodule

### rtl/lbsc_run_track.sv
// Run lamp sampling state and steady/blinking/off classification.
`include "assert_macros.svh"

module lbsc_run_track (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [lbsc_pkg::TIME_W-1:0]   now_ms,
    input  logic                          burst_lit,
    input  lbsc_pkg::run_cfg_t            cfg,
    output lbsc_pkg::run_res_t            res
);
    import lbsc_pkg::*;

    logic              sampled_once_reg;
    logic              last_lit_reg;
    logic              ever_lit_reg;
    logic [TIME_W-1:0] last_sample_time_reg;
    logic [TIME_W-1:0] lit_since_time_reg;
    logic [TIME_W-1:0] last_lit_time_reg;

    logic              sampled_once_next;
    logic              last_lit_next;
    logic              ever_lit_next;
    logic [TIME_W-1:0] last_sample_time_next;
    logic [TIME_W-1:0] lit_since_time_next;
    logic [TIME_W-1:0] last_lit_time_next;

    logic [TIME_W-1:0] since_sample;
    logic              due;
    logic              gap;
    logic              lit_sample;
    logic              restart;
    logic [TIME_W-1:0] lit_span;
    logic [TIME_W-1:0] dark_span;

    always_comb
    begin
        since_sample = now_ms - last_sample_time_reg;
        due          = !sampled_once_reg || (since_sample >= TIME_W'(cfg.poll_interval_ms));
        gap          = sampled_once_reg && (since_sample > TIME_W'(cfg.max_gap_ms));
        lit_sample   = due && burst_lit;
        restart      = lit_sample && (!last_lit_reg || gap || !sampled_once_reg);

        // spans measured against the updated stamps; a fresh stamp is now
        lit_span  = restart    ? '0 : (now_ms - lit_since_time_reg);
        dark_span = lit_sample ? '0 : (now_ms - last_lit_time_reg);

        last_lit_next         = due ? burst_lit : last_lit_reg;
        ever_lit_next         = ever_lit_reg || lit_sample;
        sampled_once_next     = sampled_once_reg || due;
        last_sample_time_next = due ? now_ms : last_sample_time_reg;
        lit_since_time_next   = restart ? now_ms : lit_since_time_reg;
        last_lit_time_next    = lit_sample ? now_ms : last_lit_time_reg;

        res.sampled = due;
        if (last_lit_next && (lit_span >= TIME_W'(cfg.steady_hold_ms)))
        begin
            res.state = RUN_STEADY;
        end
        else if (ever_lit_next && (dark_span < TIME_W'(cfg.blink_timeout_ms)))
        begin
            res.state = RUN_BLINKING;
        end
        else
        begin
            res.state = RUN_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampled_once_reg     <= 1'b0;
            last_lit_reg         <= 1'b0;
            ever_lit_reg         <= 1'b0;
            last_sample_time_reg <= '0;
            lit_since_time_reg   <= '0;
            last_lit_time_reg    <= '0;
        end
        else if (step)
        begin
            sampled_once_reg     <= sampled_once_next;
            last_lit_reg         <= last_lit_next;
            ever_lit_reg         <= ever_lit_next;
            last_sample_time_reg <= last_sample_time_next;
            lit_since_time_reg   <= lit_since_time_next;
            last_lit_time_reg    <= last_lit_time_next;
        end
    end

    // once sampled, the lamp never returns to the unsampled state
    `ASSERT_NEXT(a_sampled_sticky, sampled_once_reg, sampled_once_reg)
    // the very first item always takes a sample
    `ASSERT_IMPLY(a_first_samples, step && !sampled_once_reg, res.sampled)
    // steady on needs a lit latest sample
    `ASSERT_IMPLY(a_steady_lit, res.state == RUN_STEADY, last_lit_next)

endmodule

### rtl/lamp_blink_steady_classifier.sv
// Top level of the lamp blink/steady classifier.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | now_ms, run_samples, oil_samples, overload_samples
//  out     | out_valid / out_ready| run_state, run_sampled, oil_on, overload_on
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle sustained while out_ready is high; an accepted item passes the
//  input register -> popcount, 32-bit time subtract and compare -> result
//  register, with the run lamp state updated as an item leaves the input register.
//  Reset (rst_n low, asynchronous) empties both registers and restores the
//  configuration defaults and the run lamp history.
//  A stalled result holds the input register; a new item is still taken
//  while the result register drains. cfg_ready is always high.
`include "assert_macros.svh"

module lamp_blink_steady_classifier #(
    parameter int SAMPLE_COUNT = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lbsc_pkg::TIME_W-1:0]        now_ms,
    input  logic [lbsc_pkg::BURST_W-1:0]       run_samples,
    input  logic [lbsc_pkg::BURST_W-1:0]       oil_samples,
    input  logic [lbsc_pkg::BURST_W-1:0]       overload_samples,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         run_state,
    output logic                               run_sampled,
    output logic                               oil_on,
    output logic                               overload_on,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lbsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lbsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lbsc_pkg::*;

    // configuration registers
    logic [THR_W-1:0] active_threshold_reg;
    run_cfg_t         run_cfg_reg;

    // input stage
    logic               stage_valid_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [BURST_W-1:0] run_samples_reg;
    logic [BURST_W-1:0] oil_samples_reg;
    logic [BURST_W-1:0] overload_samples_reg;

    // result stage
    logic       out_valid_reg;
    run_state_t run_state_reg;
    logic       run_sampled_reg;
    logic       oil_on_reg;
    logic       overload_on_reg;

    logic     advance;   // result register free to load this cycle
    logic     step;      // item leaves the input stage
    logic     in_take;
    logic     run_lit;
    logic     oil_lit;
    logic     overload_lit;
    run_res_t run_res;

    assign advance   = !out_valid_reg || out_ready;
    assign step      = stage_valid_reg && advance;
    assign in_ready  = !stage_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_threshold_reg         <= RST_ACTIVE_THRESHOLD;
            run_cfg_reg.poll_interval_ms <= RST_POLL_INTERVAL;
            run_cfg_reg.max_gap_ms       <= RST_MAX_GAP;
            run_cfg_reg.steady_hold_ms   <= RST_STEADY;
            run_cfg_reg.blink_timeout_ms <= RST_BLINK_TIMEOUT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACTIVE_THRESHOLD: active_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_POLL_INTERVAL:    run_cfg_reg.poll_interval_ms <= cfg_data;
                CFG_MAX_GAP:          run_cfg_reg.max_gap_ms       <= cfg_data;
                CFG_STEADY:           run_cfg_reg.steady_hold_ms   <= cfg_data;
                CFG_BLINK_TIMEOUT:    run_cfg_reg.blink_timeout_ms <= cfg_data;
                default:              ;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg              <= now_ms;
            run_samples_reg      <= run_samples;
            oil_samples_reg      <= oil_samples;
            overload_samples_reg <= overload_samples;
        end
    end

    lbsc_burst_count #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_run_count (
        .samples   (run_samples_reg),
        .threshold (active_threshold_reg),
        .lit       (run_lit)
    );

    lbsc_burst_count #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_oil_count (
        .samples   (oil_samples_reg),
        .threshold (active_threshold_reg),
        .lit       (oil_lit)
    );

    lbsc_burst_count #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_overload_count (
        .samples   (overload_samples_reg),
        .threshold (active_threshold_reg),
        .lit       (overload_lit)
    );

    lbsc_run_track u_run_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .now_ms    (now_reg),
        .burst_lit (run_lit),
        .cfg       (run_cfg_reg),
        .res       (run_res)
    );

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            run_state_reg   <= run_res.state;
            run_sampled_reg <= run_res.sampled;
            oil_on_reg      <= oil_lit;
            overload_on_reg <= overload_lit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign run_state   = run_state_reg;
    assign run_sampled = run_sampled_reg;
    assign oil_on      = oil_on_reg;
    assign overload_on = overload_on_reg;

    // an empty result register always lets a new item in
    `ASSERT_IMPLY(a_ready_when_empty, !out_valid_reg, in_ready)
    // a result only appears from an occupied input stage
    `ASSERT_IMPLY(a_result_from_stage, $rose(out_valid_reg), $past(stage_valid_reg))
    // a blocked input stage keeps its item
    `ASSERT_NEXT(a_stage_holds, stage_valid_reg && !advance,
                 stage_valid_reg && $stable(now_reg))

endmodule
